// ----- rtl/fsnp_pkg.sv -----
// Shared types, constants and a helper function of the format string number printer.
package fsnp_pkg;

    localparam int ARG_BITS   = 64;
    localparam int MAX_DIGITS = 20;

    localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W     = $clog2(ARG_BITS + 1);
    localparam int DEC32_BITS = 32;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;

    typedef struct packed {
        logic [7:0]  ch;
        logic [63:0] arg;
        logic        string_end;
    } fsnp_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       newline;
        logic       last;
    } fsnp_out_t;

    typedef enum logic [1:0] {
        PH_TEXT    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_U       = 2'd2
    } fsnp_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MINUS,
        ST_ZERO,
        ST_X,
        ST_DIGITS
    } fsnp_state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD_DEC,
        CMD_LOAD_HEX
    } fsnp_cmd_t;

    typedef struct packed {
        fsnp_cmd_t              cmd;
        logic [ARG_BITS-1:0]    value;
        logic [CNT_W-1:0]       nbits;
        logic [DIG_IDX_W-1:0]   rd_idx;
    } fsnp_bcd_ctrl_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] digit;
    } fsnp_bcd_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] c;
        unique case (nibble)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/fsnp_bcd.sv -----
// Digit store with a shift-and-add-3 binary to decimal unit and a direct hex loader.
module fsnp_bcd (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fsnp_pkg::fsnp_bcd_ctrl_t    ctrl,
    output fsnp_pkg::fsnp_bcd_status_t  status
);

    localparam int NDIG = fsnp_pkg::MAX_DIGITS;
    localparam int AB   = fsnp_pkg::ARG_BITS;

    logic [3:0]                   digit_reg [NDIG];
    logic [3:0]                   digit_next [NDIG];
    logic [3:0]                   adj [NDIG];
    logic [AB-1:0]                bin_reg, bin_next;
    logic [fsnp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic [NDIG*4-1:0]            hex_wide;

    assign hex_wide = (NDIG*4)'(ctrl.value);

    always_comb begin
        // Each digit of five or more gets three added before the doubling shift.
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end
        for (int i = 0; i < NDIG; i++) begin
            digit_next[i] = digit_reg[i];
        end
        bin_next  = bin_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg) begin
            digit_next[0] = {adj[0][2:0], bin_reg[AB-1]};
            for (int i = 1; i < NDIG; i++) begin
                digit_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
            bin_next = bin_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fsnp_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end else begin
            unique case (ctrl.cmd)
                fsnp_pkg::CMD_LOAD_DEC: begin
                    for (int i = 0; i < NDIG; i++) begin
                        digit_next[i] = 4'd0;
                    end
                    bin_next  = ctrl.value;
                    cnt_next  = ctrl.nbits;
                    busy_next = 1'b1;
                end
                fsnp_pkg::CMD_LOAD_HEX: begin
                    for (int i = 0; i < NDIG; i++) begin
                        digit_next[i] = hex_wide[i*4 +: 4];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NDIG; i++) begin
            digit_reg[i] <= digit_next[i];
        end
        bin_reg <= bin_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign status.busy  = busy_reg;
    assign status.digit = digit_reg[ctrl.rd_idx];

endmodule

// ----- rtl/format_string_number_printer.sv -----
// Top level: format string parser, output sequencer and output register.
//
//  Channel | Ports                       | Payload
//  --------+-----------------------------+---------------------------------
//  input   | s_valid, s_ready, s_data    | fsnp_in_t  {ch, arg, string_end}
//  result  | m_valid, m_ready, m_data    | fsnp_out_t {out_char, newline, last}
//
// A plain character, line feed or %c goes straight to the output register. %d runs 32
// bits and %ul 64 bits through the shift-and-add-3 loop of the digit unit; %p and %x load
// the digit store directly. Digit output then scans the 20-entry digit store from the top,
// one entry per cycle while the result is not stalled, after any prefix characters.
// Reset clears the parse phase, the sequencer and the output valid. A stalled result
// holds the sequencer in its output states; input is taken only when it is idle and the output register is free.
module format_string_number_printer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsnp_pkg::fsnp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fsnp_pkg::fsnp_out_t m_data
);

    localparam int AB = fsnp_pkg::ARG_BITS;

    fsnp_pkg::fsnp_state_t        state_reg, state_next;
    fsnp_pkg::fsnp_phase_t        phase_reg, phase_next;
    logic [fsnp_pkg::DIG_IDX_W-1:0] idx_reg, idx_next;
    logic                         lead_reg, lead_next;
    logic                         neg_reg, neg_next;
    logic                         m_valid_reg, m_valid_next;
    fsnp_pkg::fsnp_out_t          m_data_reg, m_data_next;

    fsnp_pkg::fsnp_bcd_ctrl_t     bcd_ctrl;
    fsnp_pkg::fsnp_bcd_status_t   bcd_status;

    logic        slot_free;
    logic        accept;
    logic [31:0] mag32;

    fsnp_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bcd_ctrl),
        .status  (bcd_status)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == fsnp_pkg::ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign mag32     = s_data.arg[31] ? 32'd0 - s_data.arg[31:0] : s_data.arg[31:0];

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        lead_next    = lead_reg;
        neg_next     = neg_reg;
        m_valid_next = (m_valid_reg && !m_ready);
        m_data_next  = m_data_reg;
        bcd_ctrl.cmd    = fsnp_pkg::CMD_NONE;
        bcd_ctrl.value  = s_data.arg[AB-1:0];
        bcd_ctrl.nbits  = fsnp_pkg::CNT_W'(AB);
        bcd_ctrl.rd_idx = idx_reg;

        unique case (state_reg)
            fsnp_pkg::ST_IDLE: begin
                idx_next  = fsnp_pkg::DIG_IDX_W'(fsnp_pkg::MAX_DIGITS - 1);
                lead_next = 1'b1;
                if (accept) begin
                    phase_next = fsnp_pkg::PH_TEXT;
                    unique case (phase_reg)
                        fsnp_pkg::PH_PERCENT: begin
                            // An unknown conversion character matches none of these.
                            if (s_data.ch == fsnp_pkg::CH_LOWER_D) begin
                                bcd_ctrl.cmd   = fsnp_pkg::CMD_LOAD_DEC;
                                bcd_ctrl.value = AB'(mag32) << (AB - fsnp_pkg::DEC32_BITS);
                                bcd_ctrl.nbits = fsnp_pkg::CNT_W'(fsnp_pkg::DEC32_BITS);
                                neg_next       = s_data.arg[31];
                                state_next     = fsnp_pkg::ST_CONV;
                            end else if (s_data.ch == fsnp_pkg::CH_LOWER_U) begin
                                phase_next = fsnp_pkg::PH_U;
                            end else if (s_data.ch == fsnp_pkg::CH_LOWER_C) begin
                                m_valid_next = 1'b1;
                                m_data_next  = '{out_char: s_data.arg[7:0], newline: 1'b0,
                                                 last: 1'b1};
                            end else if (s_data.ch == fsnp_pkg::CH_LOWER_P) begin
                                bcd_ctrl.cmd = fsnp_pkg::CMD_LOAD_HEX;
                                state_next   = fsnp_pkg::ST_ZERO;
                            end else if (s_data.ch == fsnp_pkg::CH_LOWER_X) begin
                                bcd_ctrl.cmd   = fsnp_pkg::CMD_LOAD_HEX;
                                bcd_ctrl.value = AB'(s_data.arg[31:0]);
                                state_next     = fsnp_pkg::ST_ZERO;
                            end
                        end
                        fsnp_pkg::PH_U: begin
                            if (s_data.ch == fsnp_pkg::CH_LOWER_L) begin
                                bcd_ctrl.cmd = fsnp_pkg::CMD_LOAD_DEC;
                                neg_next     = 1'b0;
                                state_next   = fsnp_pkg::ST_CONV;
                            end
                        end
                        default: begin
                            // Normal text; the unused phase code behaves the same way.
                            priority if (s_data.ch == fsnp_pkg::CH_PERCENT &&
                                         !s_data.string_end) begin
                                phase_next = fsnp_pkg::PH_PERCENT;
                            end else if (s_data.ch == fsnp_pkg::CH_LF) begin
                                m_valid_next = 1'b1;
                                m_data_next  = '{out_char: fsnp_pkg::CH_LF, newline: 1'b1,
                                                 last: 1'b1};
                            end else begin
                                m_valid_next = 1'b1;
                                m_data_next  = '{out_char: s_data.ch, newline: 1'b0,
                                                 last: 1'b1};
                            end
                        end
                    endcase
                    if (s_data.string_end) begin
                        phase_next = fsnp_pkg::PH_TEXT;
                    end
                end
            end
            fsnp_pkg::ST_CONV: begin
                if (!bcd_status.busy) begin
                    state_next = neg_reg ? fsnp_pkg::ST_MINUS : fsnp_pkg::ST_DIGITS;
                end
            end
            fsnp_pkg::ST_MINUS: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: fsnp_pkg::CH_MINUS, newline: 1'b0, last: 1'b0};
                    state_next   = fsnp_pkg::ST_DIGITS;
                end
            end
            fsnp_pkg::ST_ZERO: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: fsnp_pkg::CH_ZERO, newline: 1'b0, last: 1'b0};
                    state_next   = fsnp_pkg::ST_X;
                end
            end
            fsnp_pkg::ST_X: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: fsnp_pkg::CH_LOWER_X, newline: 1'b0,
                                     last: 1'b0};
                    state_next   = fsnp_pkg::ST_DIGITS;
                end
            end
            fsnp_pkg::ST_DIGITS: begin
                // Leading zeros are skipped, but the lowest digit always prints.
                if (lead_reg && bcd_status.digit == 4'd0 && idx_reg != '0) begin
                    idx_next = idx_reg - 1'b1;
                end else if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: fsnp_pkg::hex_char(bcd_status.digit),
                                     newline: 1'b0, last: (idx_reg == '0)};
                    lead_next    = 1'b0;
                    idx_next     = idx_reg - 1'b1;
                    if (idx_reg == '0) begin
                        state_next = fsnp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = fsnp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        idx_reg    <= idx_next;
        lead_reg   <= lead_next;
        neg_reg    <= neg_next;
        if (!aresetn) begin
            state_reg   <= fsnp_pkg::ST_IDLE;
            phase_reg   <= fsnp_pkg::PH_TEXT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // The conversion loop only runs while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bcd_status.busy |-> state_reg == fsnp_pkg::ST_CONV)
        else $error("digit unit busy outside the conversion state");

    // No new transaction is taken while a number is still being produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !bcd_status.busy && state_reg == fsnp_pkg::ST_IDLE)
        else $error("input ready while the sequencer is active");

    // A newline request always carries the line feed code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.newline |-> m_data.out_char == fsnp_pkg::CH_LF && m_data.last)
        else $error("newline request with a wrong character");

    // Leaving the digit state always goes with the final character of the run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fsnp_pkg::ST_DIGITS && state_next == fsnp_pkg::ST_IDLE
        |=> m_valid && m_data.last)
        else $error("number run ended without a final character");
`endif

endmodule
